### hw/rtl/tmps_pkg.sv
`default_nettype none

package tmps_pkg;

	// command queue geometry
	localparam int QUEUE_DEPTH = 8;
	localparam int QUEUE_AW    = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int FILL_W      = $clog2(QUEUE_DEPTH + 1);

	// field widths
	localparam int OP_W     = 2;
	localparam int MOTION_W = 2;
	localparam int AMP_W    = 15;
	localparam int DUR_W    = 16;
	localparam int TICKS_W  = DUR_W + 1;
	localparam int SETP_W   = 16;
	localparam int COUNT_W  = 4;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 16;

	typedef logic [QUEUE_AW-1:0] ptr_t;
	typedef logic [FILL_W-1:0]   fill_t;
	typedef logic [TICKS_W-1:0]  ticks_t;

	typedef enum logic [OP_W-1:0] {
		OP_TICK  = 2'd0,
		OP_PUSH  = 2'd1,
		OP_CLEAR = 2'd2
	} op_t;

	typedef enum logic [MOTION_W-1:0] {
		MOT_FRONT = 2'd0,
		MOT_BACK  = 2'd1,
		MOT_LEFT  = 2'd2,
		MOT_RIGHT = 2'd3
	} motion_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_AMPLITUDE     = 3'd0,
		REG_SIDE_MOVE     = 3'd1,
		REG_SIDE_COUNTER  = 3'd2,
		REG_FRONT_MOVE    = 3'd3,
		REG_FRONT_COUNTER = 3'd4,
		REG_BACK_MOVE     = 3'd5,
		REG_BACK_COUNTER  = 3'd6
	} cfg_idx_t;

	// reset values of the registers
	localparam logic [AMP_W-1:0] RST_AMPLITUDE     = 15'd5120;
	localparam logic [DUR_W-1:0] RST_SIDE_MOVE     = 16'd750;
	localparam logic [DUR_W-1:0] RST_SIDE_COUNTER  = 16'd150;
	localparam logic [DUR_W-1:0] RST_FRONT_MOVE    = 16'd1000;
	localparam logic [DUR_W-1:0] RST_FRONT_COUNTER = 16'd400;
	localparam logic [DUR_W-1:0] RST_BACK_MOVE     = 16'd750;
	localparam logic [DUR_W-1:0] RST_BACK_COUNTER  = 16'd800;

	typedef struct packed {
		logic [AMP_W-1:0] amplitude;
		logic [DUR_W-1:0] side_move;
		logic [DUR_W-1:0] side_counter;
		logic [DUR_W-1:0] front_move;
		logic [DUR_W-1:0] front_counter;
		logic [DUR_W-1:0] back_move;
		logic [DUR_W-1:0] back_counter;
	} cfg_t;

	// sequencer state after a phase load
	typedef struct packed {
		logic                run;
		logic [1:0]          phase;
		ticks_t              ticks;
	} load_t;

endpackage

`default_nettype wire

### hw/rtl/tmps_if.sv
`default_nettype none

interface tmps_in_if;
	logic                                valid;
	logic                                ready;
	logic [tmps_pkg::OP_W-1:0]           op;
	logic [tmps_pkg::MOTION_W-1:0]       motion;

	modport source (output valid, output op, output motion, input ready);
	modport sink   (input valid, input op, input motion, output ready);
endinterface

interface tmps_out_if;
	logic                                valid;
	logic                                ready;
	logic signed [tmps_pkg::SETP_W-1:0]  x_setpoint;
	logic signed [tmps_pkg::SETP_W-1:0]  y_setpoint;
	logic                                busy_res;
	logic [tmps_pkg::COUNT_W-1:0]        queue_count;
	logic                                dropped;

	modport source (output valid, output x_setpoint, output y_setpoint, output busy_res,
		output queue_count, output dropped, input ready);
	modport sink   (input valid, input x_setpoint, input y_setpoint, input busy_res,
		input queue_count, input dropped, output ready);
endinterface

interface tmps_cfg_if;
	logic                                valid;
	logic                                ready;
	logic [tmps_pkg::CFG_IDX_W-1:0]      index;
	logic [tmps_pkg::CFG_DATA_W-1:0]     data;

	modport source (output valid, output index, output data, input ready);
	modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

### hw/rtl/timed_motion_pulse_sequencer_top.sv
// channel  dir  handshake      payload
// cmd      in   valid/ready    op, motion
// res      out  valid/ready    x_setpoint, y_setpoint, busy_res, queue_count, dropped
// cfg      in   valid/ready    index, data (ready is always high)
//
// one transaction per cycle sustained on cmd and res while res is not stalled; a result
// follows its command through the input register, then the result register
// the queue, pointers and pulse timer update in the cycle a command leaves the
// input register; the queue head is kept prefetched in a register
// arst_n clears control state and loads the register reset values; queue entries
// are not cleared
// a stalled res holds its result and the input register; cmd stalls only when both are full
`default_nettype none

module timed_motion_pulse_sequencer_top (
	input  wire           clk,
	input  wire           arst_n,
	tmps_in_if.sink       cmd,
	tmps_out_if.source    res,
	tmps_cfg_if.sink      cfg
);

	// configuration registers
	tmps_pkg::cfg_t cfg_q;

	// input register
	logic                              valid_s1;
	logic [tmps_pkg::OP_W-1:0]         op_s1;
	logic [tmps_pkg::MOTION_W-1:0]     motion_s1;

	// sequencer and queue state
	logic                              running_q;
	logic [tmps_pkg::MOTION_W-1:0]     cur_motion_q;
	logic [1:0]                        phase_q;
	tmps_pkg::ticks_t                  ticks_q;
	tmps_pkg::ptr_t                    head_q;
	tmps_pkg::ptr_t                    tail_q;
	tmps_pkg::fill_t                   fill_q;
	logic [tmps_pkg::MOTION_W-1:0]     head_data_q;
	logic [tmps_pkg::MOTION_W-1:0]     queue_mem [tmps_pkg::QUEUE_DEPTH];

	// result register
	logic                              res_valid_q;
	logic signed [tmps_pkg::SETP_W-1:0] x_q;
	logic signed [tmps_pkg::SETP_W-1:0] y_q;
	logic                              busy_q;
	logic [tmps_pkg::COUNT_W-1:0]      count_q;
	logic                              dropped_q;

	// next-state values
	logic                              advance;
	logic                              running_n;
	logic [tmps_pkg::MOTION_W-1:0]     cur_motion_n;
	logic [1:0]                        phase_n;
	tmps_pkg::ticks_t                  ticks_n;
	tmps_pkg::ptr_t                    head_n;
	tmps_pkg::ptr_t                    tail_n;
	tmps_pkg::fill_t                   fill_n;
	logic                              wr_en;
	logic                              dropped_n;
	tmps_pkg::ticks_t                  ticks_dec;
	tmps_pkg::load_t                   ld;
	logic                              positive;
	logic [tmps_pkg::SETP_W-1:0]       amp_ext;
	logic [tmps_pkg::SETP_W-1:0]       setp_val;
	logic signed [tmps_pkg::SETP_W-1:0] x_n;
	logic signed [tmps_pkg::SETP_W-1:0] y_n;

	// phase lengths of a motion, in ticks
	function automatic tmps_pkg::ticks_t phase_len(
		input logic [tmps_pkg::MOTION_W-1:0] m,
		input logic [1:0]                    p,
		input tmps_pkg::cfg_t                c
	);
		logic [tmps_pkg::DUR_W-1:0] mv;
		logic [tmps_pkg::DUR_W-1:0] ct;
		logic [tmps_pkg::DUR_W-1:0] mv2;
		logic [tmps_pkg::DUR_W-1:0] ct2;
		tmps_pkg::ticks_t           len;
		case (m)
			tmps_pkg::MOT_FRONT: begin
				mv = c.front_move; ct = c.front_counter;
				mv2 = c.back_move; ct2 = c.back_counter;
			end
			tmps_pkg::MOT_BACK: begin
				mv = c.back_move; ct = c.back_counter;
				mv2 = c.front_move; ct2 = c.front_counter;
			end
			default: begin
				mv = c.side_move; ct = c.side_counter;
				mv2 = c.side_move; ct2 = c.side_counter;
			end
		endcase
		case (p)
			2'd0:    len = {1'b0, mv};
			2'd1:    len = {1'b0, ct} + {1'b0, mv2};
			default: len = {1'b0, ct2};
		endcase
		return len;
	endfunction

	// first phase at or after p with a nonzero length, else idle
	function automatic tmps_pkg::load_t load_from(
		input logic [tmps_pkg::MOTION_W-1:0] m,
		input logic [1:0]                    p,
		input tmps_pkg::cfg_t                c
	);
		tmps_pkg::ticks_t l0;
		tmps_pkg::ticks_t l1;
		tmps_pkg::ticks_t l2;
		tmps_pkg::load_t  r;
		l0 = phase_len(m, 2'd0, c);
		l1 = phase_len(m, 2'd1, c);
		l2 = phase_len(m, 2'd2, c);
		r = '0;
		if (p == 2'd0 && l0 != '0) begin
			r.run = 1'b1; r.phase = 2'd0; r.ticks = l0;
		end else if (p <= 2'd1 && l1 != '0) begin
			r.run = 1'b1; r.phase = 2'd1; r.ticks = l1;
		end else if (p <= 2'd2 && l2 != '0) begin
			r.run = 1'b1; r.phase = 2'd2; r.ticks = l2;
		end
		return r;
	endfunction

	function automatic tmps_pkg::ptr_t ptr_inc(input tmps_pkg::ptr_t p);
		return (p == tmps_pkg::ptr_t'(tmps_pkg::QUEUE_DEPTH - 1)) ? '0
			: p + tmps_pkg::ptr_t'(1);
	endfunction

	// configuration writes: always ready, unknown indexes ignored
	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.amplitude     <= tmps_pkg::RST_AMPLITUDE;
			cfg_q.side_move     <= tmps_pkg::RST_SIDE_MOVE;
			cfg_q.side_counter  <= tmps_pkg::RST_SIDE_COUNTER;
			cfg_q.front_move    <= tmps_pkg::RST_FRONT_MOVE;
			cfg_q.front_counter <= tmps_pkg::RST_FRONT_COUNTER;
			cfg_q.back_move     <= tmps_pkg::RST_BACK_MOVE;
			cfg_q.back_counter  <= tmps_pkg::RST_BACK_COUNTER;
		end else if (cfg.valid) begin
			case (cfg.index)
				tmps_pkg::REG_AMPLITUDE:     cfg_q.amplitude <= cfg.data[tmps_pkg::AMP_W-1:0];
				tmps_pkg::REG_SIDE_MOVE:     cfg_q.side_move     <= cfg.data;
				tmps_pkg::REG_SIDE_COUNTER:  cfg_q.side_counter  <= cfg.data;
				tmps_pkg::REG_FRONT_MOVE:    cfg_q.front_move    <= cfg.data;
				tmps_pkg::REG_FRONT_COUNTER: cfg_q.front_counter <= cfg.data;
				tmps_pkg::REG_BACK_MOVE:     cfg_q.back_move     <= cfg.data;
				tmps_pkg::REG_BACK_COUNTER:  cfg_q.back_counter  <= cfg.data;
				default: ;
			endcase
		end
	end

	// the input register moves on when the result register is free or drains now
	assign advance   = valid_s1 && (!res_valid_q || res.ready);
	assign cmd.ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (cmd.ready) begin
			valid_s1 <= cmd.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.ready && cmd.valid) begin
			op_s1     <= cmd.op;
			motion_s1 <= cmd.motion;
		end
	end

	// one command: tick, push or clear
	always_comb begin
		running_n    = running_q;
		cur_motion_n = cur_motion_q;
		phase_n      = phase_q;
		ticks_n      = ticks_q;
		head_n       = head_q;
		tail_n       = tail_q;
		fill_n       = fill_q;
		wr_en        = 1'b0;
		dropped_n    = 1'b0;
		ticks_dec    = ticks_q - tmps_pkg::ticks_t'(1);
		ld           = '0;
		if (advance) begin
			case (op_s1)
				tmps_pkg::OP_TICK: begin
					// count down the running phase, step to the next one at zero
					if (running_q) begin
						if (ticks_dec == '0) begin
							ld        = load_from(cur_motion_q, phase_q + 2'd1, cfg_q);
							running_n = ld.run;
							phase_n   = ld.phase;
							ticks_n   = ld.ticks;
						end else begin
							ticks_n = ticks_dec;
						end
					end
					// idle: start the oldest queued motion
					if (!running_n && fill_q != '0) begin
						cur_motion_n = head_data_q;
						head_n       = ptr_inc(head_q);
						fill_n       = fill_q - tmps_pkg::fill_t'(1);
						ld           = load_from(head_data_q, 2'd0, cfg_q);
						running_n    = ld.run;
						phase_n      = ld.phase;
						ticks_n      = ld.ticks;
					end
				end
				tmps_pkg::OP_PUSH: begin
					if (fill_q == tmps_pkg::fill_t'(tmps_pkg::QUEUE_DEPTH)) begin
						dropped_n = 1'b1;
					end else begin
						wr_en  = 1'b1;
						tail_n = ptr_inc(tail_q);
						fill_n = fill_q + tmps_pkg::fill_t'(1);
					end
				end
				tmps_pkg::OP_CLEAR: begin
					// pending commands go, the running motion stays
					head_n = tail_q;
					fill_n = '0;
				end
				default: ;
			endcase
		end
	end

	// setpoint of the phase now in force: main and late phases share a sign
	always_comb begin
		positive = (cur_motion_n == tmps_pkg::MOT_FRONT) || (cur_motion_n == tmps_pkg::MOT_RIGHT);
		if (phase_n == 2'd1) begin
			positive = !positive;
		end
		amp_ext  = {1'b0, cfg_q.amplitude};
		setp_val = positive ? amp_ext : (~amp_ext + tmps_pkg::SETP_W'(1));
		x_n = '0;
		y_n = '0;
		if (running_n) begin
			if (cur_motion_n == tmps_pkg::MOT_FRONT || cur_motion_n == tmps_pkg::MOT_BACK) begin
				y_n = setp_val;
			end else begin
				x_n = setp_val;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			running_q    <= 1'b0;
			cur_motion_q <= '0;
			phase_q      <= '0;
			ticks_q      <= '0;
			head_q       <= '0;
			tail_q       <= '0;
			fill_q       <= '0;
		end else begin
			running_q    <= running_n;
			cur_motion_q <= cur_motion_n;
			phase_q      <= phase_n;
			ticks_q      <= ticks_n;
			head_q       <= head_n;
			tail_q       <= tail_n;
			fill_q       <= fill_n;
		end
	end

	// queue memory, head entry prefetched into a register with write bypass
	always_ff @(posedge clk) begin
		if (wr_en) begin
			queue_mem[tail_q] <= motion_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en && tail_q == head_n) begin
			head_data_q <= motion_s1;
		end else begin
			head_data_q <= queue_mem[head_n];
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (advance) begin
			res_valid_q <= 1'b1;
		end else if (res.ready) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			x_q       <= x_n;
			y_q       <= y_n;
			busy_q    <= running_n;
			count_q   <= tmps_pkg::COUNT_W'(fill_n);
			dropped_q <= dropped_n;
		end
	end

	assign res.valid       = res_valid_q;
	assign res.x_setpoint  = x_q;
	assign res.y_setpoint  = y_q;
	assign res.busy_res    = busy_q;
	assign res.queue_count = count_q;
	assign res.dropped     = dropped_q;

endmodule

`default_nettype wire

### hw/rtl/tmps_checker.sv
`default_nettype none

module tmps_checker (
	input wire                                clk,
	input wire                                arst_n,
	input wire                                res_valid,
	input wire                                res_ready,
	input wire signed [tmps_pkg::SETP_W-1:0]  x_setpoint,
	input wire signed [tmps_pkg::SETP_W-1:0]  y_setpoint,
	input wire                                busy_res,
	input wire [tmps_pkg::COUNT_W-1:0]        queue_count,
	input wire                                dropped
);

	// a drop only happens with the queue full
	a_drop_full: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && dropped |-> queue_count == tmps_pkg::COUNT_W'(tmps_pkg::QUEUE_DEPTH))
		else $error("drop reported with queue not full");

	// idle sequencer drives no setpoint
	a_idle_zero: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !busy_res |-> x_setpoint == '0 && y_setpoint == '0)
		else $error("setpoint while idle");

	// only one axis moves at a time
	a_one_axis: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && x_setpoint != '0 |-> y_setpoint == '0)
		else $error("both axes driven");

	// a stalled result holds
	a_res_hold: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_ready |=> res_valid && $stable(x_setpoint) && $stable(y_setpoint)
			&& $stable(busy_res) && $stable(queue_count) && $stable(dropped))
		else $error("stalled result changed");

endmodule

bind timed_motion_pulse_sequencer_top tmps_checker u_tmps_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.res_valid   (res.valid),
	.res_ready   (res.ready),
	.x_setpoint  (res.x_setpoint),
	.y_setpoint  (res.y_setpoint),
	.busy_res    (res.busy_res),
	.queue_count (res.queue_count),
	.dropped     (res.dropped)
);

`default_nettype wire

### bench/tb_timed_motion_pulse_sequencer_top.sv
`default_nettype none

module tb_timed_motion_pulse_sequencer_top;
	timeunit 1ns;
	timeprecision 1ps;

	import tmps_pkg::*;

	// op code the block treats as a no-op
	localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;

	// pulse phases: main stroke, counter stroke, return stroke
	localparam logic [1:0] PH_MAIN    = 2'd0;
	localparam logic [1:0] PH_COUNTER = 2'd1;
	localparam logic [1:0] PH_RETURN  = 2'd2;

	// cycles without any accepted transaction before the run is declared hung
	localparam int WATCHDOG_LIMIT = 5000;

	// one result transaction as the bench expects it
	typedef struct packed {
		logic [SETP_W-1:0]  x;
		logic [SETP_W-1:0]  y;
		logic               busy;
		logic [COUNT_W-1:0] count;
		logic               dropped;
	} setpoint_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	tmps_in_if  cmd_ch ();
	tmps_out_if res_ch ();
	tmps_cfg_if cfg_ch ();

	timed_motion_pulse_sequencer_top dut (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (cmd_ch),
		.res    (res_ch),
		.cfg    (cfg_ch)
	);

	// 10 ns clock
	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// ---------------------------------------------------------------
	// sequencer predictor: own copy of registers, queue and pulse timer
	// ---------------------------------------------------------------
	cfg_t        regs;
	motion_t     queue_mem [QUEUE_DEPTH];
	int unsigned q_head;
	int unsigned q_tail;
	int unsigned q_fill;
	logic        seq_run;
	motion_t     seq_motion;
	logic [1:0]  seq_phase;
	ticks_t      seq_ticks;

	// results predicted but not yet seen on the result channel
	setpoint_t expected_setpoints [$];

	int  mismatches;
	int  hold_off_cycles;  // request for a long result stall, served by the sink
	bit  quiet;            // no random idling on either side
	int  idle_cycles;

	function automatic void reset_predictor();
		regs = '{amplitude: RST_AMPLITUDE, side_move: RST_SIDE_MOVE,
			side_counter: RST_SIDE_COUNTER, front_move: RST_FRONT_MOVE,
			front_counter: RST_FRONT_COUNTER, back_move: RST_BACK_MOVE,
			back_counter: RST_BACK_COUNTER};
		q_head     = 0;
		q_tail     = 0;
		q_fill     = 0;
		seq_run    = 1'b0;
		seq_motion = MOT_FRONT;
		seq_phase  = PH_MAIN;
		seq_ticks  = '0;
	endfunction

	function automatic void apply_register(cfg_idx_t idx, logic [CFG_DATA_W-1:0] data);
		case (idx)
			REG_AMPLITUDE:     regs.amplitude     = data[AMP_W-1:0];
			REG_SIDE_MOVE:     regs.side_move     = data;
			REG_SIDE_COUNTER:  regs.side_counter  = data;
			REG_FRONT_MOVE:    regs.front_move    = data;
			REG_FRONT_COUNTER: regs.front_counter = data;
			REG_BACK_MOVE:     regs.back_move     = data;
			REG_BACK_COUNTER:  regs.back_counter  = data;
			default: ;
		endcase
	endfunction

	// length of one phase; the counter stroke also absorbs the opposite move
	function automatic ticks_t phase_ticks(motion_t m, logic [1:0] p);
		logic [DUR_W-1:0] mv, ct, mv2, ct2;
		case (m)
			MOT_FRONT: begin
				mv = regs.front_move; ct = regs.front_counter;
				mv2 = regs.back_move; ct2 = regs.back_counter;
			end
			MOT_BACK: begin
				mv = regs.back_move; ct = regs.back_counter;
				mv2 = regs.front_move; ct2 = regs.front_counter;
			end
			default: begin
				mv = regs.side_move; ct = regs.side_counter;
				mv2 = regs.side_move; ct2 = regs.side_counter;
			end
		endcase
		case (p)
			PH_MAIN:    return {1'b0, mv};
			PH_COUNTER: return {1'b0, ct} + {1'b0, mv2};
			default:    return {1'b0, ct2};
		endcase
	endfunction

	// enter the first phase from start on that has a nonzero length, else go idle
	function automatic void load_phase(int start);
		ticks_t len;
		for (int p = start; p <= int'(PH_RETURN); p++) begin
			len = phase_ticks(seq_motion, 2'(p));
			if (len != '0) begin
				seq_phase = 2'(p);
				seq_ticks = len;
				seq_run   = 1'b1;
				return;
			end
		end
		seq_run   = 1'b0;
		seq_phase = PH_MAIN;
		seq_ticks = '0;
	endfunction

	function automatic setpoint_t advance_sequencer(logic [OP_W-1:0] op, motion_t mot);
		setpoint_t        r;
		logic             positive;
		logic [SETP_W-1:0] level;
		r = '0;
		case (op)
			OP_TICK: begin
				if (seq_run) begin
					seq_ticks = seq_ticks - 1'b1;
					if (seq_ticks == '0)
						load_phase(int'(seq_phase) + 1);
				end
				// an idle sequencer pops on the same tick
				if (!seq_run && q_fill > 0) begin
					seq_motion = queue_mem[q_head];
					q_head = (q_head + 1) % QUEUE_DEPTH;
					q_fill--;
					load_phase(int'(PH_MAIN));
				end
			end
			OP_PUSH: begin
				if (q_fill >= QUEUE_DEPTH) begin
					r.dropped = 1'b1;
				end else begin
					queue_mem[q_tail] = mot;
					q_tail = (q_tail + 1) % QUEUE_DEPTH;
					q_fill++;
				end
			end
			OP_CLEAR: begin
				// pending commands go, the running motion stays
				q_head = q_tail;
				q_fill = 0;
			end
			default: ;
		endcase
		if (seq_run) begin
			positive = (seq_motion == MOT_FRONT || seq_motion == MOT_RIGHT);
			if (seq_phase == PH_COUNTER)
				positive = !positive;
			level = {1'b0, regs.amplitude};
			if (!positive)
				level = ~level + 1'b1;
			if (seq_motion == MOT_FRONT || seq_motion == MOT_BACK)
				r.y = level;
			else
				r.x = level;
		end
		r.busy  = seq_run;
		r.count = COUNT_W'(q_fill);
		return r;
	endfunction

	// ---------------------------------------------------------------
	// result checker: every accepted result against the oldest prediction
	// ---------------------------------------------------------------
	function automatic void check_setpoint(setpoint_t got);
		setpoint_t want;
		if (expected_setpoints.size() == 0) begin
			mismatches++;
			if (mismatches <= 10)
				$display("%0t: result transaction with nothing expected:", $realtime,
					" x=%0d y=%0d busy=%0b count=%0d dropped=%0b",
					$signed(got.x), $signed(got.y), got.busy, got.count, got.dropped);
			return;
		end
		want = expected_setpoints.pop_front();
		if (got.x !== want.x || got.y !== want.y || got.busy !== want.busy ||
				got.count !== want.count || got.dropped !== want.dropped) begin
			mismatches++;
			if (mismatches <= 10) begin
				$display("%0t: mismatch expected x=%0d y=%0d busy=%0b count=%0d dropped=%0b",
					$realtime, $signed(want.x), $signed(want.y), want.busy, want.count,
					want.dropped);
				$display("%0t:          got x=%0d y=%0d busy=%0b count=%0d dropped=%0b",
					$realtime, $signed(got.x), $signed(got.y), got.busy, got.count,
					got.dropped);
			end
		end
	endfunction

	// sampled at the rising edge, so only pre-edge values are seen
	always @(posedge clk) begin
		if (arst_n && res_ch.valid && res_ch.ready)
			check_setpoint(setpoint_t'{res_ch.x_setpoint, res_ch.y_setpoint,
				res_ch.busy_res, res_ch.queue_count, res_ch.dropped});
	end

	// hang detector: any accepted transaction on any channel restarts the count
	always @(posedge clk) begin
		if (!arst_n || (cmd_ch.valid && cmd_ch.ready) || (res_ch.valid && res_ch.ready) ||
				(cfg_ch.valid && cfg_ch.ready)) begin
			idle_cycles <= 0;
		end else begin
			idle_cycles <= idle_cycles + 1;
			if (idle_cycles >= WATCHDOG_LIMIT) begin
				$display("TB_ERROR");
				$finish;
			end
		end
	end

	// result sink: random stall bursts, plus a long hold-off on request
	initial begin : result_sink
		int stall;
		res_ch.ready <= 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			@(posedge clk);
			if (hold_off_cycles > 0) begin
				stall = hold_off_cycles;
				hold_off_cycles = 0;
				res_ch.ready <= 1'b0;
				repeat (stall) @(posedge clk);
				res_ch.ready <= 1'b1;
			end else if (!quiet && $urandom_range(0, 11) == 0) begin
				stall = $urandom_range(1, 16);
				res_ch.ready <= 1'b0;
				repeat (stall) @(posedge clk);
				res_ch.ready <= 1'b1;
			end else begin
				res_ch.ready <= 1'b1;
			end
		end
	end

	// ---------------------------------------------------------------
	// stimulus helpers
	// ---------------------------------------------------------------

	// one command transaction; valid stays high so back-to-back items need no gap
	task automatic send_item(input logic [OP_W-1:0] op, input logic [MOTION_W-1:0] mot);
		int gap;
		if (!quiet && $urandom_range(0, 9) == 0) begin
			gap = $urandom_range(1, 16);
			cmd_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		cmd_ch.valid  <= 1'b1;
		cmd_ch.op     <= op;
		cmd_ch.motion <= mot;
		do @(posedge clk); while (!cmd_ch.ready);
		expected_setpoints.push_back(advance_sequencer(op, motion_t'(mot)));
	endtask

	// stop offering commands and let every outstanding result come out
	task automatic wait_results_done();
		cmd_ch.valid <= 1'b0;
		while (expected_setpoints.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	// idle point, then all seven registers in index order
	task automatic program_timing(input logic [CFG_DATA_W-1:0] amp,
			input logic [DUR_W-1:0] sm, input logic [DUR_W-1:0] sc,
			input logic [DUR_W-1:0] fm, input logic [DUR_W-1:0] fc,
			input logic [DUR_W-1:0] bm, input logic [DUR_W-1:0] bc);
		cfg_idx_t              reg_order [7];
		logic [CFG_DATA_W-1:0] reg_value [7];
		reg_order = '{REG_AMPLITUDE, REG_SIDE_MOVE, REG_SIDE_COUNTER, REG_FRONT_MOVE,
			REG_FRONT_COUNTER, REG_BACK_MOVE, REG_BACK_COUNTER};
		reg_value = '{amp, sm, sc, fm, fc, bm, bc};
		wait_results_done();
		for (int i = 0; i < 7; i++) begin
			cfg_ch.valid <= 1'b1;
			cfg_ch.index <= reg_order[i];
			cfg_ch.data  <= reg_value[i];
			do @(posedge clk); while (!cfg_ch.ready);
			apply_register(reg_order[i], reg_value[i]);
		end
		cfg_ch.valid <= 1'b0;
	endtask

	// tick until the running motion and everything queued behind it is done
	task automatic run_out_motions();
		while (seq_run || q_fill != 0)
			send_item(OP_TICK, MOTION_W'($urandom_range(0, 3)));
	endtask

	// mostly ticks, a share of pushes, a few clears and no-ops
	task automatic send_random_item(input int push_pct);
		int              r;
		logic [OP_W-1:0] op;
		r = $urandom_range(0, 99);
		if (r < push_pct)
			op = OP_PUSH;
		else if (r < push_pct + 4)
			op = OP_CLEAR;
		else if (r < push_pct + 7)
			op = OP_UNUSED;
		else
			op = OP_TICK;
		send_item(op, MOTION_W'($urandom_range(0, 3)));
	endtask

	// short phases keep motions brief so the queue churns
	function automatic logic [DUR_W-1:0] pick_ticks();
		case ($urandom_range(0, 9))
			0, 1:    return '0;
			9:       return DUR_W'($urandom_range(5, 24));
			default: return DUR_W'($urandom_range(1, 4));
		endcase
	endfunction

	// ---------------------------------------------------------------
	// tests
	// ---------------------------------------------------------------

	// reset register values: no-op, idle tick, empty clear, then a back motion whose
	// main stroke runs its reset length; later strokes take lengths set mid-motion
	task automatic test_reset_values();
		send_item(OP_UNUSED, MOT_RIGHT);
		send_item(OP_TICK, MOT_LEFT);
		send_item(OP_CLEAR, MOT_BACK);
		send_item(OP_PUSH, MOT_BACK);
		repeat (4) send_item(OP_TICK, MOT_FRONT);
		program_timing(16'd300, 16'd2, 16'd1, 16'd3, 16'd1, 16'd2, 16'd2);
		run_out_motions();
	endtask

	// every motion, queue full and drop, clear while running, zero-length phases
	task automatic test_directed_sequences();
		// full amplitude; front and back lose their return stroke
		program_timing(16'h7FFF, 16'd1, 16'd2, 16'd2, 16'd0, 16'd1, 16'd0);
		send_item(OP_PUSH, MOT_FRONT);
		send_item(OP_PUSH, MOT_BACK);
		send_item(OP_PUSH, MOT_LEFT);
		send_item(OP_PUSH, MOT_RIGHT);
		send_item(OP_TICK, MOT_RIGHT);
		// refill to the brim, one more push bounces
		send_item(OP_PUSH, MOT_LEFT);
		send_item(OP_PUSH, MOT_RIGHT);
		send_item(OP_PUSH, MOT_FRONT);
		send_item(OP_PUSH, MOT_BACK);
		send_item(OP_PUSH, MOT_LEFT);
		send_item(OP_PUSH, MOT_RIGHT);
		send_item(OP_UNUSED, MOT_BACK);
		repeat (3) send_item(OP_TICK, MOT_FRONT);
		// clear drops the queue, current motion keeps going
		send_item(OP_CLEAR, MOT_RIGHT);
		repeat (3) send_item(OP_TICK, MOT_BACK);
		send_item(OP_PUSH, MOT_RIGHT);
		run_out_motions();

		// all phases empty: pop and finish on the same tick; bit 15 of amplitude is dropped
		program_timing(16'h8000, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0);
		send_item(OP_PUSH, MOT_FRONT);
		send_item(OP_PUSH, MOT_LEFT);
		repeat (3) send_item(OP_TICK, MOT_RIGHT);

		// only the counter and return strokes left for side moves, amplitude masked to full scale
		program_timing(16'hFFFF, 16'd0, 16'd3, 16'd0, 16'd0, 16'd0, 16'd2);
		send_item(OP_PUSH, MOT_LEFT);
		send_item(OP_PUSH, MOT_BACK);
		run_out_motions();
	endtask

	// the counter stroke alone: two registers summed with a carry past the low byte
	task automatic test_longest_phase();
		program_timing(16'h0001, 16'hFFFF, 16'hFFFF, 16'h0000, 16'h0081, 16'h007F, 16'h0000);
		quiet = 1'b1;
		send_item(OP_PUSH, MOT_FRONT);
		run_out_motions();
		quiet = 1'b0;
	endtask

	// hold the result side off long enough that the command side backs up
	task automatic test_result_backpressure();
		program_timing(16'd1234, 16'd2, 16'd1, 16'd3, 16'd1, 16'd2, 16'd2);
		hold_off_cycles = 64;
		repeat (40) send_random_item(30);
	endtask

	// random traffic under a new register set per phase, last phase without idling
	task automatic test_random_traffic();
		logic [CFG_DATA_W-1:0] amp;
		int                    push_pct;
		for (int ph = 0; ph < 10; ph++) begin
			case ($urandom_range(0, 3))
				0:       amp = '0;
				1:       amp = 16'h7FFF;
				default: amp = CFG_DATA_W'($urandom);
			endcase
			program_timing(amp, pick_ticks(), pick_ticks(), pick_ticks(), pick_ticks(),
				pick_ticks(), pick_ticks());
			if (ph == 9)
				quiet = 1'b1;
			push_pct = $urandom_range(10, 45);
			repeat (30) send_random_item(push_pct);
		end
	endtask

	// ---------------------------------------------------------------
	// main sequence
	// ---------------------------------------------------------------
	initial begin
		cmd_ch.valid  <= 1'b0;
		cmd_ch.op     <= OP_TICK;
		cmd_ch.motion <= MOT_FRONT;
		cfg_ch.valid  <= 1'b0;
		cfg_ch.index  <= REG_AMPLITUDE;
		cfg_ch.data   <= '0;
		mismatches      = 0;
		hold_off_cycles = 0;
		quiet           = 1'b0;
		idle_cycles     = 0;
		reset_predictor();

		// reset held, then released at a rising edge
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_reset_values();
		test_directed_sequences();
		test_longest_phase();
		test_result_backpressure();
		test_random_traffic();

		wait_results_done();
		repeat (8) @(posedge clk);
		if (mismatches == 0 && expected_setpoints.size() == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

endmodule

`default_nettype wire
